@@ hdl/ospp_pkg.sv @@
// Shared types, constants and codes for the OSC packet stream parser.
package ospp_pkg;

    localparam int OSPP_MAX_TAGS = 16;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_INT   = 8'h69;
    localparam logic [7:0] CH_FLOAT = 8'h66;
    localparam logic [7:0] CH_STR   = 8'h73;
    localparam logic [7:0] CH_BLOB  = 8'h62;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] BUNDLE_WORD [7] = '{CH_HASH, 8'h62, 8'h75, 8'h6e, 8'h64, 8'h6c, 8'h65};

    typedef enum logic [3:0] {
        TK_ADDR      = 4'd0,
        TK_TAG       = 4'd1,
        TK_INT       = 4'd2,
        TK_FLOAT     = 4'd3,
        TK_STR_BYTE  = 4'd4,
        TK_STR_END   = 4'd5,
        TK_BLOB_LEN  = 4'd6,
        TK_BLOB_BYTE = 4'd7,
        TK_ELEM_LEN  = 4'd8,
        TK_ELEM_BYTE = 4'd9,
        TK_END       = 4'd10
    } token_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_COMMA  = 2'd1,
        ST_TRUNC     = 2'd2,
        ST_MANY_TAGS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,
        CLS_INT   = 3'd1,
        CLS_FLOAT = 3'd2,
        CLS_BLOB  = 3'd3,
        CLS_STR   = 3'd4
    } tag_class_t;

    typedef enum logic [14:0] {
        PH_ADDR       = 15'h0001,
        PH_ADDR_PAD   = 15'h0002,
        PH_COMMA      = 15'h0004,
        PH_TAGS       = 15'h0008,
        PH_TAG_PAD    = 15'h0010,
        PH_WORD       = 15'h0020,
        PH_STR        = 15'h0040,
        PH_STR_PAD    = 15'h0080,
        PH_BLOB       = 15'h0100,
        PH_BLOB_PAD   = 15'h0200,
        PH_SKIP       = 15'h0400,
        PH_TIMETAG    = 15'h0800,
        PH_FIRST_LEN  = 15'h1000,
        PH_ELEM_LEN   = 15'h2000,
        PH_ELEM_BYTES = 15'h4000
    } phase_t;

    typedef struct packed {
        token_kind_t kind;
        logic [31:0] value;
        logic [3:0]  arg_index;
        logic        packet_end;
        status_t     status;
        logic        same_type;
    } token_t;

    function automatic tag_class_t tag_class(input logic [7:0] c);
        tag_class_t r;
        unique case (c)
            CH_INT:   r = CLS_INT;
            CH_FLOAT: r = CLS_FLOAT;
            CH_BLOB:  r = CLS_BLOB;
            CH_STR:   r = CLS_STR;
            default:  r = CLS_NONE;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/ospp_tag_scan.sv @@
// Priority search for the next type tag that takes argument bytes.
module ospp_tag_scan import ospp_pkg::*; #(
    parameter int MAX_TAGS = OSPP_MAX_TAGS,
    parameter int PW = $clog2(MAX_TAGS + 1)
) (
    input  logic [MAX_TAGS-1:0] arg_mask,
    input  logic [MAX_TAGS-1:0] str_mask,
    input  logic [PW-1:0]       start,
    output logic                found,
    output logic                is_str,
    output logic [PW-1:0]       pos
);
    always_comb begin
        found  = 1'b0;
        is_str = 1'b0;
        pos    = '0;
        for (int i = 0; i < MAX_TAGS; i++) begin
            if (!found && arg_mask[i] && PW'(i) >= start) begin
                found  = 1'b1;
                is_str = str_mask[i];
                pos    = PW'(i);
            end
        end
    end
endmodule

@@ hdl/ospp_core.sv @@
// Parser state and per-byte step logic: one byte in, at most one token out.
module ospp_core import ospp_pkg::*; #(
    parameter int MAX_TAGS = OSPP_MAX_TAGS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       tok_valid,
    output token_t     tok
);
    localparam int PW = $clog2(MAX_TAGS + 1);
    localparam int IW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

    phase_t      phase_reg, phase_next;
    logic [1:0]  bwi_reg, bwi_next;
    logic [31:0] wacc_reg, wacc_next;
    logic [PW-1:0] tcount_reg, tcount_next;
    logic [PW-1:0] tpos_reg, tpos_next;
    logic [31:0] brem_reg, brem_next;
    logic        uniform_reg, uniform_next;
    logic        in_bundle_reg, in_bundle_next;
    logic [31:0] elem_left_reg, elem_left_next;
    status_t     fault_reg, fault_next;
    logic [3:0]  addr_len_reg, addr_len_next;
    logic        bmatch_reg, bmatch_next;
    logic [7:0]  first_tag_reg, first_tag_next;

    tag_class_t  cls_reg [MAX_TAGS];
    logic        tag_wr;

    logic [MAX_TAGS-1:0] arg_mask, str_mask;
    logic        f0_found, f0_str, f1_found, f1_str;
    logic [PW-1:0] f0_pos, f1_pos, tpos_inc;

    always_comb begin
        for (int i = 0; i < MAX_TAGS; i++) begin
            arg_mask[i] = (cls_reg[i] != CLS_NONE) && (PW'(i) < tcount_reg);
            str_mask[i] = (cls_reg[i] == CLS_STR);
        end
    end

    assign tpos_inc = tpos_reg + PW'(1);

    ospp_tag_scan #(.MAX_TAGS(MAX_TAGS), .PW(PW)) u_scan_cur (
        .arg_mask(arg_mask), .str_mask(str_mask), .start(tpos_reg),
        .found(f0_found), .is_str(f0_str), .pos(f0_pos)
    );

    ospp_tag_scan #(.MAX_TAGS(MAX_TAGS), .PW(PW)) u_scan_nxt (
        .arg_mask(arg_mask), .str_mask(str_mask), .start(tpos_inc),
        .found(f1_found), .is_str(f1_str), .pos(f1_pos)
    );

    always_comb begin
        logic        msg, counted, have, complete;
        logic [1:0]  pos;
        logic [31:0] el_dec, shifted, br_dec;
        token_kind_t kind;
        logic [31:0] val;
        logic [PW-1:0] idx;
        tag_class_t  cur_cls;

        phase_next     = phase_reg;
        bwi_next       = bwi_reg;
        wacc_next      = wacc_reg;
        tcount_next    = tcount_reg;
        tpos_next      = tpos_reg;
        brem_next      = brem_reg;
        uniform_next   = uniform_reg;
        in_bundle_next = in_bundle_reg;
        elem_left_next = elem_left_reg;
        fault_next     = fault_reg;
        addr_len_next  = addr_len_reg;
        bmatch_next    = bmatch_reg;
        first_tag_next = first_tag_reg;
        tag_wr         = 1'b0;
        have           = 1'b0;
        kind           = TK_ADDR;
        val            = '0;
        idx            = '0;

        msg = (phase_reg == PH_ADDR) || (phase_reg == PH_ADDR_PAD) || (phase_reg == PH_COMMA)
           || (phase_reg == PH_TAGS) || (phase_reg == PH_TAG_PAD) || (phase_reg == PH_WORD)
           || (phase_reg == PH_STR) || (phase_reg == PH_STR_PAD) || (phase_reg == PH_BLOB)
           || (phase_reg == PH_BLOB_PAD);
        counted = in_bundle_reg && (msg || phase_reg == PH_SKIP);
        pos     = bwi_reg;
        el_dec  = elem_left_reg - 32'd1;
        shifted = {wacc_reg[23:0], data_byte};
        br_dec  = brem_reg - 32'd1;
        cur_cls = cls_reg[tpos_reg[IW-1:0]];

        if (counted) elem_left_next = el_dec;
        if (msg) bwi_next = pos + 2'd1;

        unique case (phase_reg)
            PH_ADDR: begin
                if (data_byte != CH_NUL) begin
                    have = 1'b1; kind = TK_ADDR; val = {24'd0, data_byte};
                    if (addr_len_reg < 4'd7) begin
                        if (data_byte != BUNDLE_WORD[addr_len_reg[2:0]]) bmatch_next = 1'b0;
                    end else begin
                        bmatch_next = 1'b0;
                    end
                    if (addr_len_reg < 4'd8) addr_len_next = addr_len_reg + 4'd1;
                end else if (bmatch_reg && addr_len_reg == 4'd7 && !in_bundle_reg) begin
                    in_bundle_next = 1'b1;
                    brem_next      = 32'd8;
                    phase_next     = PH_TIMETAG;
                end else begin
                    phase_next = (pos == 2'd3) ? PH_COMMA : PH_ADDR_PAD;
                end
            end
            PH_ADDR_PAD: begin
                if (pos == 2'd3) phase_next = PH_COMMA;
            end
            PH_COMMA: begin
                if (data_byte == CH_COMMA) begin
                    phase_next = PH_TAGS;
                end else begin
                    if (fault_reg == ST_OK) fault_next = ST_NO_COMMA;
                    phase_next = PH_SKIP;
                end
            end
            PH_TAGS: begin
                if (data_byte != CH_NUL) begin
                    if (tcount_reg >= PW'(MAX_TAGS)) begin
                        if (fault_reg == ST_OK) fault_next = ST_MANY_TAGS;
                        phase_next = PH_SKIP;
                    end else begin
                        if (tcount_reg == '0) first_tag_next = data_byte;
                        else if (data_byte != first_tag_reg) uniform_next = 1'b0;
                        tag_wr = 1'b1;
                        have = 1'b1; kind = TK_TAG; val = {24'd0, data_byte}; idx = tcount_reg;
                        tcount_next = tcount_reg + PW'(1);
                    end
                end else if (pos == 2'd3) begin
                    wacc_next  = '0;
                    tpos_next  = f0_found ? f0_pos : tcount_reg;
                    phase_next = !f0_found ? PH_SKIP : (f0_str ? PH_STR : PH_WORD);
                end else begin
                    phase_next = PH_TAG_PAD;
                end
            end
            PH_TAG_PAD, PH_STR_PAD, PH_BLOB_PAD: begin
                if (pos == 2'd3) begin
                    wacc_next  = '0;
                    tpos_next  = f0_found ? f0_pos : tcount_reg;
                    phase_next = !f0_found ? PH_SKIP : (f0_str ? PH_STR : PH_WORD);
                end
            end
            PH_WORD: begin
                wacc_next = shifted;
                if (pos == 2'd3) begin
                    have = 1'b1; val = shifted; idx = tpos_reg;
                    if (cur_cls == CLS_BLOB && shifted != '0) begin
                        kind       = TK_BLOB_LEN;
                        brem_next  = shifted;
                        phase_next = PH_BLOB;
                    end else begin
                        kind = (cur_cls == CLS_BLOB) ? TK_BLOB_LEN
                             : (cur_cls == CLS_FLOAT) ? TK_FLOAT : TK_INT;
                        if (cur_cls == CLS_BLOB) brem_next = shifted;
                        wacc_next  = '0;
                        tpos_next  = f1_found ? f1_pos : tcount_reg;
                        phase_next = !f1_found ? PH_SKIP : (f1_str ? PH_STR : PH_WORD);
                    end
                end
            end
            PH_STR: begin
                have = 1'b1; idx = tpos_reg;
                if (data_byte != CH_NUL) begin
                    kind = TK_STR_BYTE; val = {24'd0, data_byte};
                    wacc_next = wacc_reg + 32'd1;
                end else begin
                    kind = TK_STR_END; val = wacc_reg;
                    if (pos == 2'd3) begin
                        wacc_next  = '0;
                        tpos_next  = f1_found ? f1_pos : tcount_reg;
                        phase_next = !f1_found ? PH_SKIP : (f1_str ? PH_STR : PH_WORD);
                    end else begin
                        tpos_next  = tpos_inc;
                        phase_next = PH_STR_PAD;
                    end
                end
            end
            PH_BLOB: begin
                have = 1'b1; kind = TK_BLOB_BYTE; val = {24'd0, data_byte}; idx = tpos_reg;
                brem_next = br_dec;
                if (br_dec == '0) begin
                    if (pos == 2'd3) begin
                        wacc_next  = '0;
                        tpos_next  = f1_found ? f1_pos : tcount_reg;
                        phase_next = !f1_found ? PH_SKIP : (f1_str ? PH_STR : PH_WORD);
                    end else begin
                        tpos_next  = tpos_inc;
                        phase_next = PH_BLOB_PAD;
                    end
                end
            end
            PH_TIMETAG: begin
                brem_next = br_dec;
                if (br_dec == '0) begin
                    phase_next = PH_FIRST_LEN; bwi_next = '0; wacc_next = '0;
                end
            end
            PH_FIRST_LEN: begin
                if (pos == 2'd3) begin
                    elem_left_next = shifted;
                    wacc_next      = '0;
                    bwi_next       = '0;
                    addr_len_next  = '0;
                    if (shifted == '0) begin
                        if (fault_reg == ST_OK) fault_next = ST_TRUNC;
                        phase_next = PH_ELEM_LEN;
                    end else begin
                        phase_next = PH_ADDR;
                    end
                end else begin
                    wacc_next = shifted;
                    bwi_next  = pos + 2'd1;
                end
            end
            PH_ELEM_LEN: begin
                if (pos == 2'd3) begin
                    have = 1'b1; kind = TK_ELEM_LEN; val = shifted;
                    brem_next = shifted;
                    wacc_next = '0;
                    bwi_next  = '0;
                    if (shifted != '0) phase_next = PH_ELEM_BYTES;
                end else begin
                    wacc_next = shifted;
                    bwi_next  = pos + 2'd1;
                end
            end
            PH_ELEM_BYTES: begin
                have = 1'b1; kind = TK_ELEM_BYTE; val = {24'd0, data_byte};
                brem_next = br_dec;
                if (br_dec == '0) begin
                    phase_next = PH_ELEM_LEN; bwi_next = '0; wacc_next = '0;
                end
            end
            default: begin
            end
        endcase

        // element length ran out: drop to the next element boundary
        if (counted && el_dec == '0) begin
            if (phase_next != PH_SKIP && fault_next == ST_OK) fault_next = ST_TRUNC;
            phase_next = PH_ELEM_LEN;
            bwi_next   = '0;
            wacc_next  = '0;
        end

        tok_valid      = have || last_byte;
        tok.kind       = have ? kind : TK_END;
        tok.value      = have ? val : '0;
        tok.arg_index  = have ? 4'(idx) : 4'd0;
        tok.packet_end = last_byte;
        tok.status     = ST_OK;
        tok.same_type  = 1'b0;

        if (last_byte) begin
            complete = in_bundle_next ? (phase_next == PH_ELEM_LEN && bwi_next == '0)
                                      : (phase_next == PH_SKIP);
            if (!complete && fault_next == ST_OK) fault_next = ST_TRUNC;
            tok.status    = fault_next;
            tok.same_type = uniform_next && (tcount_next != '0);

            phase_next     = PH_ADDR;
            bwi_next       = '0;
            wacc_next      = '0;
            tcount_next    = '0;
            tpos_next      = '0;
            brem_next      = '0;
            uniform_next   = 1'b1;
            in_bundle_next = 1'b0;
            elem_left_next = '0;
            fault_next     = ST_OK;
            addr_len_next  = '0;
            bmatch_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ADDR;
            bwi_reg       <= '0;
            wacc_reg      <= '0;
            tcount_reg    <= '0;
            tpos_reg      <= '0;
            brem_reg      <= '0;
            uniform_reg   <= 1'b1;
            in_bundle_reg <= 1'b0;
            elem_left_reg <= '0;
            fault_reg     <= ST_OK;
            addr_len_reg  <= '0;
            bmatch_reg    <= 1'b1;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            bwi_reg       <= bwi_next;
            wacc_reg      <= wacc_next;
            tcount_reg    <= tcount_next;
            tpos_reg      <= tpos_next;
            brem_reg      <= brem_next;
            uniform_reg   <= uniform_next;
            in_bundle_reg <= in_bundle_next;
            elem_left_reg <= elem_left_next;
            fault_reg     <= fault_next;
            addr_len_reg  <= addr_len_next;
            bmatch_reg    <= bmatch_next;
        end
    end

    // tag classes and first tag carry no reset; only entries below the count are read
    always_ff @(posedge aclk) begin
        if (step_en) begin
            first_tag_reg <= first_tag_next;
            if (tag_wr) cls_reg[tcount_reg[IW-1:0]] <= tag_class(data_byte);
        end
    end
endmodule

@@ hdl/osc_packet_stream_parser.sv @@
// OSC packet stream parser: byte stream in, token stream out.
//
// Slave channel: one packet byte per transaction in s_tdata[7:0], s_tlast on the
// final byte of a packet. Master channel: one token per transaction; m_tuser
// holds the token kind, m_tlast marks the token that closes the packet and
// carries status and same-type in m_tdata.
// Each accepted byte is held in an input register, stepped through the parser
// state and the token (if any) lands in the output register, from which it is
// shown on m_tvalid. One byte per cycle is sustained while m_tready stays high;
// padding and header bytes just produce no token. The argument-tag search is a
// priority encoder over the tag classes of the current message, settled within
// the step cycle.
// When m_tready is low with a token waiting, the byte already in the input
// register waits too and s_tready drops; nothing is lost or repeated.
// aresetn (synchronous, active low) empties both registers and returns the
// parser to the start of a packet; the state also returns there after each
// s_tlast byte.
module osc_packet_stream_parser import ospp_pkg::*; #(
    parameter int MAX_TAGS = OSPP_MAX_TAGS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] token_value, [35:32] arg_index,
                                   // [37:36] status, [38] same_type, [39] zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast
);
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    token_t     out_tok_reg;
    logic       step_en, s_accept, tok_valid;
    token_t     tok;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_accept = s_tvalid && s_tready;

    ospp_core #(.MAX_TAGS(MAX_TAGS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .step_en(step_en),
        .data_byte(in_byte_reg), .last_byte(in_last_reg),
        .tok_valid(tok_valid), .tok(tok)
    );

    always_comb begin
        in_valid_next = s_accept ? 1'b1 : (step_en ? 1'b0 : in_valid_reg);
        if (step_en && tok_valid) out_valid_next = 1'b1;
        else if (m_tready)        out_valid_next = 1'b0;
        else                      out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step_en && tok_valid) out_tok_reg <= tok;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_tok_reg.kind;
    assign m_tlast  = out_tok_reg.packet_end;
    assign m_tdata  = {1'b0, out_tok_reg.same_type, out_tok_reg.status,
                       out_tok_reg.arg_index, out_tok_reg.value};
endmodule

@@ hdl/ospp_checker.sv @@
// Port-level checks for the OSC packet stream parser, bound to the top level.
module ospp_checker import ospp_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled token changed");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == TK_END |-> m_tlast)
        else $error("end token without packet end");

    a_status_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[38:36] == 3'd0)
        else $error("status or same-type set mid packet");
endmodule

bind osc_packet_stream_parser ospp_checker u_ospp_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the OSC packet stream parser: byte stream in, token checks out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ospp_pkg::*;

    // Token predictor and expected-token store
    class token_scoreboard;
        token_t      expected_tokens[$];
        int          errors;
        phase_t      ph;
        bit [1:0]    biw;
        bit [31:0]   acc;
        bit [7:0]    tags [OSPP_MAX_TAGS];
        int unsigned tcnt;
        int unsigned tpos;
        bit [31:0]   brem;
        bit          uni;
        bit          inb;
        bit [31:0]   eleft;
        bit [1:0]    fault;
        int unsigned alen;
        bit          bmatch;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            ph = PH_ADDR; biw = 0; acc = 0; tcnt = 0; tpos = 0; brem = 0;
            uni = 1; inb = 0; eleft = 0; fault = ST_OK; alen = 0; bmatch = 1;
            foreach (tags[i]) tags[i] = 0;
        endfunction

        function void abort_msg(bit [1:0] code);
            if (fault == ST_OK) fault = code;
            ph = PH_SKIP;
        endfunction

        // Move to the next tag that takes argument bytes
        function void next_arg();
            bit [7:0] t;
            acc = 0;
            while (tpos < tcnt) begin
                t = tags[tpos % OSPP_MAX_TAGS];
                if (t == CH_INT || t == CH_FLOAT || t == CH_BLOB) begin
                    ph = PH_WORD;
                    return;
                end
                if (t == CH_STR) begin
                    ph = PH_STR;
                    return;
                end
                tpos++;
            end
            ph = PH_SKIP;
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            bit          have;
            token_t      tk;
            bit          msg;
            bit          counted;
            bit [1:0]    pos;
            bit          complete;
            bit [7:0]    t;
            have = 0;
            tk = '0;
            tk.kind = TK_ADDR;
            tk.status = ST_OK;
            msg = ph inside {PH_ADDR, PH_ADDR_PAD, PH_COMMA, PH_TAGS, PH_TAG_PAD, PH_WORD,
                             PH_STR, PH_STR_PAD, PH_BLOB, PH_BLOB_PAD};
            counted = inb && (msg || ph == PH_SKIP);
            pos = biw;
            if (counted) eleft--;
            if (msg) biw = pos + 2'd1;

            case (ph)
                PH_ADDR: begin
                    if (b != CH_NUL) begin
                        have = 1; tk.kind = TK_ADDR; tk.value = b;
                        if (alen < 7) begin
                            if (b != BUNDLE_WORD[alen]) bmatch = 0;
                        end else begin
                            bmatch = 0;
                        end
                        if (alen < 8) alen++;
                    end else if (bmatch && alen == 7 && !inb) begin
                        inb = 1; brem = 8; ph = PH_TIMETAG;
                    end else begin
                        ph = (pos == 3) ? PH_COMMA : PH_ADDR_PAD;
                    end
                end
                PH_ADDR_PAD: if (pos == 3) ph = PH_COMMA;
                PH_COMMA: begin
                    if (b == CH_COMMA) ph = PH_TAGS;
                    else abort_msg(ST_NO_COMMA);
                end
                PH_TAGS: begin
                    if (b != CH_NUL) begin
                        if (tcnt >= OSPP_MAX_TAGS) begin
                            abort_msg(ST_MANY_TAGS);
                        end else begin
                            if (tcnt > 0 && b != tags[0]) uni = 0;
                            tags[tcnt] = b;
                            have = 1; tk.kind = TK_TAG; tk.value = b; tk.arg_index = tcnt[3:0];
                            tcnt++;
                        end
                    end else if (pos == 3) begin
                        next_arg();
                    end else begin
                        ph = PH_TAG_PAD;
                    end
                end
                PH_TAG_PAD, PH_STR_PAD, PH_BLOB_PAD: if (pos == 3) next_arg();
                PH_WORD: begin
                    acc = {acc[23:0], b};
                    if (pos == 3) begin
                        t = tags[tpos % OSPP_MAX_TAGS];
                        have = 1; tk.value = acc; tk.arg_index = tpos[3:0];
                        if (t == CH_BLOB) begin
                            tk.kind = TK_BLOB_LEN;
                            brem = acc;
                            if (brem == 0) begin
                                tpos++;
                                next_arg();
                            end else begin
                                ph = PH_BLOB;
                            end
                        end else begin
                            tk.kind = (t == CH_FLOAT) ? TK_FLOAT : TK_INT;
                            tpos++;
                            next_arg();
                        end
                    end
                end
                PH_STR: begin
                    have = 1; tk.arg_index = tpos[3:0];
                    if (b != CH_NUL) begin
                        tk.kind = TK_STR_BYTE; tk.value = b;
                        acc++;
                    end else begin
                        tk.kind = TK_STR_END; tk.value = acc;
                        tpos++;
                        if (pos == 3) next_arg();
                        else ph = PH_STR_PAD;
                    end
                end
                PH_BLOB: begin
                    have = 1; tk.kind = TK_BLOB_BYTE; tk.value = b; tk.arg_index = tpos[3:0];
                    brem--;
                    if (brem == 0) begin
                        tpos++;
                        if (pos == 3) next_arg();
                        else ph = PH_BLOB_PAD;
                    end
                end
                PH_TIMETAG: begin
                    brem--;
                    if (brem == 0) begin
                        ph = PH_FIRST_LEN; biw = 0; acc = 0;
                    end
                end
                PH_FIRST_LEN: begin
                    acc = {acc[23:0], b};
                    if (pos == 3) begin
                        eleft = acc; acc = 0; biw = 0; alen = 0;
                        if (eleft == 0) begin
                            if (fault == ST_OK) fault = ST_TRUNC;
                            ph = PH_ELEM_LEN;
                        end else begin
                            ph = PH_ADDR;
                        end
                    end else begin
                        biw = pos + 2'd1;
                    end
                end
                PH_ELEM_LEN: begin
                    acc = {acc[23:0], b};
                    if (pos == 3) begin
                        have = 1; tk.kind = TK_ELEM_LEN; tk.value = acc;
                        brem = acc; acc = 0; biw = 0;
                        if (brem != 0) ph = PH_ELEM_BYTES;
                    end else begin
                        biw = pos + 2'd1;
                    end
                end
                PH_ELEM_BYTES: begin
                    have = 1; tk.kind = TK_ELEM_BYTE; tk.value = b;
                    brem--;
                    if (brem == 0) begin
                        ph = PH_ELEM_LEN; biw = 0; acc = 0;
                    end
                end
                default: ;
            endcase

            // first element used up its length
            if (counted && inb && eleft == 0) begin
                if (ph != PH_SKIP && fault == ST_OK) fault = ST_TRUNC;
                ph = PH_ELEM_LEN; biw = 0; acc = 0;
            end

            if (last) begin
                complete = inb ? (ph == PH_ELEM_LEN && biw == 0) : (ph == PH_SKIP);
                if (!complete && fault == ST_OK) fault = ST_TRUNC;
                if (!have) begin
                    tk = '0;
                    tk.kind = TK_END;
                end
                tk.packet_end = 1;
                tk.status = status_t'(fault);
                tk.same_type = uni && tcnt > 0;
                expected_tokens.push_back(tk);
                clear();
            end else if (have) begin
                expected_tokens.push_back(tk);
            end
        endfunction

        function void check(token_t got);
            token_t exp_tk;
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token kind=%0d value=%h", $time, got.kind, got.value);
                errors++;
                return;
            end
            exp_tk = expected_tokens.pop_front();
            if (got.kind != exp_tk.kind || got.value != exp_tk.value
                || got.arg_index != exp_tk.arg_index || got.packet_end != exp_tk.packet_end
                || got.status != exp_tk.status || got.same_type != exp_tk.same_type) begin
                $display("%0t: token mismatch expected kind=%0d value=%h idx=%0d end=%0b st=%0d same=%0b",
                         $time, exp_tk.kind, exp_tk.value, exp_tk.arg_index, exp_tk.packet_end,
                         exp_tk.status, exp_tk.same_type);
                $display("%0t:                actual   kind=%0d value=%h idx=%0d end=%0b st=%0d same=%0b",
                         $time, got.kind, got.value, got.arg_index, got.packet_end,
                         got.status, got.same_type);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    token_scoreboard sb = new();
    bit [7:0]  pkt[$];
    int        hold_req = 0;
    int        hold_left = 0;
    int        stall_left = 0;
    bit        quiet_rx = 0;
    bit        quiet_tx = 0;
    int        bytes_sent = 0;
    token_t    got;

    osc_packet_stream_parser u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls plus requested long hold-off
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 0;
        end else if (!quiet_rx && $urandom_range(0, 5) == 0) begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(0, 2);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.kind       = token_kind_t'(m_tuser);
            got.value      = m_tdata[31:0];
            got.arg_index  = m_tdata[35:32];
            got.status     = status_t'(m_tdata[37:36]);
            got.same_type  = m_tdata[38];
            got.packet_end = m_tlast;
            sb.check(got);
            if (m_tdata[39] !== 1'b0) begin
                $display("%0t: m_tdata[39] expected 0 actual %b", $time, m_tdata[39]);
                sb.errors++;
            end
        end
    end

    task automatic send_byte(bit [7:0] b, bit last);
        int gap;
        s_tvalid <= 1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b, last);
        bytes_sent++;
        gap = 0;
        if (!quiet_tx && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 25) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_packet();
        if (pkt.size() == 0) pkt.push_back($urandom);
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.expected_tokens.size() != 0) @(posedge aclk);
    endtask

    function automatic void put_word(bit [31:0] w);
        pkt.push_back(w[31:24]);
        pkt.push_back(w[23:16]);
        pkt.push_back(w[15:8]);
        pkt.push_back(w[7:0]);
    endfunction

    function automatic void pad4();
        while (pkt.size() % 4 != 0) pkt.push_back(CH_NUL);
    endfunction

    function automatic bit [7:0] any_char();
        return $urandom_range(1, 255);
    endfunction

    function automatic void put_str(int n);
        repeat (n) pkt.push_back(any_char());
        pkt.push_back(CH_NUL);
        pad4();
    endfunction

    function automatic bit [7:0] pick_tag();
        bit [7:0] t;
        case ($urandom_range(0, 5))
            0: t = CH_INT;
            1: t = CH_FLOAT;
            2: t = CH_STR;
            3: t = CH_BLOB;
            4: t = any_char();
            default: t = CH_INT;
        endcase
        return t;
    endfunction

    // Message starting at a word boundary; tags given, arguments random
    function automatic void put_msg(bit [7:0] tl[$], bit comma_ok);
        int n;
        pkt.push_back(8'h2f);
        put_str($urandom_range(0, 6));
        pkt.push_back(comma_ok ? CH_COMMA : any_char());
        if (!comma_ok && pkt[pkt.size() - 1] == CH_COMMA) pkt[pkt.size() - 1] = 8'h21;
        foreach (tl[i]) pkt.push_back(tl[i]);
        pkt.push_back(CH_NUL);
        pad4();
        foreach (tl[i]) begin
            case (tl[i])
                CH_INT, CH_FLOAT: begin
                    case ($urandom_range(0, 3))
                        0: put_word(32'h0);
                        1: put_word(32'hffff_ffff);
                        default: put_word($urandom);
                    endcase
                end
                CH_STR: put_str($urandom_range(0, 6));
                CH_BLOB: begin
                    n = $urandom_range(0, 6);
                    put_word(n);
                    repeat (n) pkt.push_back($urandom);
                    pad4();
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void put_rand_msg(int ntags, bit comma_ok);
        bit [7:0] tl[$];
        repeat (ntags) tl.push_back(pick_tag());
        put_msg(tl, comma_ok);
    endfunction

    // Bundle with a first message element and later raw elements
    function automatic void put_bundle(int first_adj, int n_later, bit first_is_bundle_addr);
        int at;
        int len;
        bit [7:0] tl[$];
        foreach (BUNDLE_WORD[i]) pkt.push_back(BUNDLE_WORD[i]);
        pkt.push_back(CH_NUL);
        repeat (8) pkt.push_back($urandom);
        at = pkt.size();
        put_word(0);
        if (first_is_bundle_addr) begin
            foreach (BUNDLE_WORD[i]) pkt.push_back(BUNDLE_WORD[i]);
            pkt.push_back(CH_NUL);
            pkt.push_back(CH_COMMA);
            pkt.push_back(CH_INT);
            pad4();
            put_word($urandom);
        end else begin
            repeat ($urandom_range(0, 4)) tl.push_back(pick_tag());
            put_msg(tl, 1);
        end
        len = pkt.size() - at - 4 + first_adj;
        if (len < 0) len = 0;
        // extra bytes beyond the message when the length overshoots
        while (pkt.size() - at - 4 < len) pkt.push_back($urandom);
        while (pkt.size() - at - 4 > len) void'(pkt.pop_back());
        pkt[at + 2] = len[15:8];
        pkt[at + 3] = len[7:0];
        repeat (n_later) begin
            len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
            put_word(len);
            repeat (len) pkt.push_back($urandom);
        end
    endfunction

    initial begin
        bit [7:0] tl[$];
        int kind;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed packets
        put_msg('{}, 1); send_packet();
        tl = '{CH_INT, CH_FLOAT, CH_STR, CH_BLOB}; put_msg(tl, 1); send_packet();
        tl = '{CH_INT, CH_INT, CH_INT}; put_msg(tl, 1); send_packet();
        tl = '{8'h54, CH_STR, 8'h4e, CH_BLOB}; put_msg(tl, 1); send_packet();
        put_rand_msg(3, 0); send_packet();
        put_rand_msg(17, 1); send_packet();
        put_rand_msg(16, 1); send_packet();
        put_rand_msg(2, 1); repeat (5) pkt.push_back($urandom); send_packet();
        put_rand_msg(3, 1); pkt = pkt[0:pkt.size() / 2]; send_packet();
        pkt.push_back(8'hff); send_packet();
        pkt.push_back(CH_NUL); send_packet();
        put_bundle(0, 3, 0); send_packet();
        put_bundle(0, 2, 1); send_packet();
        put_bundle(-3, 1, 0); send_packet();
        put_bundle(5, 1, 0); send_packet();
        put_bundle(0, 0, 0); pkt = pkt[0:17]; send_packet();
        foreach (BUNDLE_WORD[i]) pkt.push_back(BUNDLE_WORD[i]);
        pkt.push_back(CH_NUL);
        repeat (8) pkt.push_back(8'h00);
        put_word(0); put_word(0); put_word(2); pkt.push_back(8'haa); pkt.push_back(8'h55);
        send_packet();

        // sender waits for every token
        drain();

        // receiver holds off long while bytes keep coming
        hold_req = 120;
        tl = '{CH_STR, CH_BLOB, CH_INT}; put_msg(tl, 1); put_bundle(0, 2, 0);
        send_packet();

        while (bytes_sent < 700) begin
            kind = $urandom_range(0, 19);
            quiet_tx = ($urandom_range(0, 4) == 0);
            quiet_rx = ($urandom_range(0, 4) == 0);
            if (kind < 9) put_rand_msg($urandom_range(0, 5), 1);
            else if (kind < 14) put_bundle(($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) - 3
                                                                        : 0,
                                           $urandom_range(0, 3), $urandom_range(0, 7) == 0);
            else if (kind == 14) put_rand_msg($urandom_range(1, 3), 0);
            else if (kind == 15) put_rand_msg($urandom_range(16, 19), 1);
            else if (kind == 16) begin
                put_rand_msg($urandom_range(1, 4), 1);
                pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
            end else if (kind == 17) begin
                put_rand_msg($urandom_range(0, 3), 1);
                repeat ($urandom_range(1, 6)) pkt.push_back($urandom);
            end else if (kind == 18) begin
                repeat ($urandom_range(1, 12)) pkt.push_back($urandom);
            end else begin
                put_bundle(0, 3, 0);
                pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
            end
            send_packet();
        end

        drain();
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/ospp_pkg.sv
hdl/ospp_tag_scan.sv
hdl/ospp_core.sv
hdl/osc_packet_stream_parser.sv
hdl/ospp_checker.sv
tb/sv/testbench.sv
